/* design/cfb_pkg.sv */
// shared constants, types and crc function for the crc16 frame builder
package cfb_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
  localparam logic [BYTE_W-1:0] SYNC_A   = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_B   = 8'h55;

  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_ID     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 1'b1;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  typedef struct packed {
    logic              is_start;
    logic              close;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] seq;
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] data;
  } gen_cmd_t;

  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* design/cfb_in_if.sv */
// request channel: valid/ready plus request type and payload byte
interface cfb_in_if;
  import cfb_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] payload_byte;

  modport source (output valid, output req_type, output payload_byte, input ready);
  modport sink   (input valid, input req_type, input payload_byte, output ready);
endinterface

/* design/cfb_out_if.sv */
// frame byte channel: valid/ready plus frame byte and run/frame flags
interface cfb_out_if;
  import cfb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              last_in_run;
  logic              frame_end;

  modport source (output valid, output frame_byte, output last_in_run, output frame_end,
                  input ready);
  modport sink   (input valid, input frame_byte, input last_in_run, input frame_end,
                  output ready);
endinterface

/* design/cfb_gen.sv */
// byte sequencer: emits header, payload and crc bytes, folding the crc per byte
module cfb_gen (
  input  logic              clk,
  input  logic              rst_n,
  input  cfb_pkg::gen_cmd_t cmd,
  input  logic              cmd_load,
  output logic              gen_ready,
  cfb_out_if.source         out_ch
);
  import cfb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SYNC_A,
    ST_SYNC_B,
    ST_LEN,
    ST_SEQ,
    ST_ID,
    ST_HCRC_LO,
    ST_HCRC_HI,
    ST_DATA,
    ST_FCRC_LO,
    ST_FCRC_HI
  } step_t;

  step_t             step_r, step_nxt;
  logic              close_r;
  logic [BYTE_W-1:0] len_r, seq_r, id_r, data_r, hold_r;
  logic [CRC_W-1:0]  crc_r;
  logic              out_valid_r, out_last_r, out_end_r;
  logic [BYTE_W-1:0] out_byte_r;

  logic              busy, fire;
  logic [BYTE_W-1:0] cur_byte;
  logic              cur_last, cur_end, cur_fold, cur_hold;
  logic [CRC_W-1:0]  crc_base;

  assign busy = (step_r != ST_IDLE);
  assign fire = busy && (!out_valid_r || out_ch.ready);
  assign gen_ready = !busy || (fire && cur_last);

  always_comb begin
    cur_byte = data_r;
    cur_last = 1'b0;
    cur_end  = 1'b0;
    cur_fold = 1'b1;
    cur_hold = 1'b0;
    crc_base = crc_r;
    step_nxt = ST_IDLE;
    case (step_r)
      ST_SYNC_A: begin
        cur_byte = SYNC_A;
        crc_base = CRC_INIT;
        step_nxt = ST_SYNC_B;
      end
      ST_SYNC_B: begin
        cur_byte = SYNC_B;
        step_nxt = ST_LEN;
      end
      ST_LEN: begin
        cur_byte = len_r;
        step_nxt = ST_SEQ;
      end
      ST_SEQ: begin
        cur_byte = seq_r;
        step_nxt = ST_ID;
      end
      ST_ID: begin
        cur_byte = id_r;
        step_nxt = ST_HCRC_LO;
      end
      ST_HCRC_LO: begin
        cur_byte = crc_r[BYTE_W-1:0];
        cur_hold = 1'b1;
        step_nxt = ST_HCRC_HI;
      end
      ST_HCRC_HI: begin
        cur_byte = hold_r;
        cur_last = !close_r;
        step_nxt = close_r ? ST_FCRC_LO : ST_IDLE;
      end
      ST_DATA: begin
        cur_byte = data_r;
        cur_last = !close_r;
        step_nxt = close_r ? ST_FCRC_LO : ST_IDLE;
      end
      ST_FCRC_LO: begin
        cur_byte = crc_r[BYTE_W-1:0];
        cur_fold = 1'b0;
        cur_hold = 1'b1;
        step_nxt = ST_FCRC_HI;
      end
      ST_FCRC_HI: begin
        cur_byte = hold_r;
        cur_fold = 1'b0;
        cur_last = 1'b1;
        cur_end  = 1'b1;
        step_nxt = ST_IDLE;
      end
      default: begin
        cur_fold = 1'b0;
        step_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      out_valid_r <= 1'b0;
      crc_r       <= CRC_INIT;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= cur_byte;
        out_last_r  <= cur_last;
        out_end_r   <= cur_end;
        if (cur_fold) begin
          crc_r <= crc_fold(crc_base, cur_byte);
        end
        if (cur_hold) begin
          hold_r <= crc_r[CRC_W-1:BYTE_W];
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd_load) begin
        step_r  <= cmd.is_start ? ST_SYNC_A : ST_DATA;
        close_r <= cmd.close;
        len_r   <= cmd.len;
        seq_r   <= cmd.seq;
        id_r    <= cmd.id;
        data_r  <= cmd.data;
      end else if (fire) begin
        step_r  <= step_nxt;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_byte  = out_byte_r;
  assign out_ch.last_in_run = out_last_r;
  assign out_ch.frame_end   = out_end_r;

endmodule

/* design/crc16_frame_builder.sv */
// top level: configuration registers, frame bookkeeping and byte sequencer
// A start beat yields seven frame bytes (AA 55 LEN SEQ ID and the header CRC, low byte
// first), nine when payload_length is 0; a payload beat yields its byte, followed by the
// two frame CRC bytes on the last one. Frame bytes leave at one per cycle while the sink is
// ready, from a single output register, and the CRC is folded one byte per cycle as each
// byte is issued. The next request is taken in the cycle its predecessor's last byte is
// issued, so payload bytes stream at one per cycle while the sink is ready. Payload beats
// outside an open frame are taken and dropped. message_id and payload_length are sampled
// on the start beat; write them only while the block is idle.
module crc16_frame_builder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfb_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  cfb_in_if.sink                          in_ch,
  cfb_out_if.source                       out_ch
);
  import cfb_pkg::*;

  logic [BYTE_W-1:0] message_id_r, payload_length_r;
  logic [BYTE_W-1:0] seq_r, remaining_r;
  logic              open_r;

  logic              gen_ready, accept, is_start, cmd_load;
  logic [BYTE_W-1:0] seq_inc;
  gen_cmd_t          cmd;

  assign in_ch.ready = gen_ready;
  assign accept      = in_ch.valid && gen_ready;
  assign is_start    = (in_ch.req_type == REQ_START);
  assign cmd_load    = accept && (is_start || open_r);
  assign seq_inc     = seq_r + BYTE_W'(1);

  always_comb begin
    cmd.is_start = is_start;
    cmd.len      = payload_length_r;
    cmd.seq      = seq_inc;
    cmd.id       = message_id_r;
    cmd.data     = in_ch.payload_byte;
    cmd.close    = is_start ? (payload_length_r == '0) : (remaining_r == BYTE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      message_id_r     <= BYTE_W'(1);
      payload_length_r <= BYTE_W'(64);
      seq_r            <= '0;
      remaining_r      <= '0;
      open_r           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MESSAGE_ID:     message_id_r     <= cfg_wdata;
          REG_PAYLOAD_LENGTH: payload_length_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd_load) begin
        if (is_start) begin
          seq_r       <= seq_inc;
          remaining_r <= payload_length_r;
          open_r      <= (payload_length_r != '0);
        end else begin
          remaining_r <= remaining_r - BYTE_W'(1);
          open_r      <= (remaining_r != BYTE_W'(1));
        end
      end
    end
  end

  cfb_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_load  (cmd_load),
    .gen_ready (gen_ready),
    .out_ch    (out_ch)
  );

endmodule
